@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/lao_pkg.sv @@
package lao_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned MagW   = 15;
  localparam int unsigned AngleW = 11;
  localparam int unsigned QuotW  = 17;
  localparam int unsigned TabAW  = 9;
  localparam int unsigned TabDW  = 8;

  localparam logic [2:0] OCT_PP   = 3'd0;
  localparam logic [2:0] OCT_PPS  = 3'd1;
  localparam logic [2:0] OCT_PN   = 3'd2;
  localparam logic [2:0] OCT_PNS  = 3'd3;
  localparam logic [2:0] OCT_NP   = 3'd4;
  localparam logic [2:0] OCT_NPS  = 3'd5;
  localparam logic [2:0] OCT_NN   = 3'd6;

  localparam logic [TabDW-1:0] DiagAngle = 8'h80;
  localparam logic [AngleW-1:0] Quarter  = 11'h100;
  localparam logic [AngleW-1:0] Half     = 11'h200;

  typedef logic [TabDW-1:0] tab_t;

  typedef struct packed {
    logic [2:0]       oct;
    logic             zero;
    logic             diag;
  } ctl_t;

  function automatic tab_t atan_lookup(input logic [TabAW-1:0] idx);
    tab_t tab [0:257];
    tab = '{
      8'd0,8'd1,8'd1,8'd2,8'd3,8'd3,8'd4,8'd4,8'd5,8'd6,8'd6,8'd7,8'd8,8'd8,8'd9,
      8'd10,8'd10,8'd11,8'd11,8'd12,8'd13,8'd13,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,
      8'd18,8'd18,8'd19,8'd20,8'd20,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd25,8'd25,
      8'd26,8'd27,8'd27,8'd28,8'd28,8'd29,8'd30,8'd30,8'd31,8'd31,8'd32,8'd33,8'd33,
      8'd34,8'd34,8'd35,8'd36,8'd36,8'd37,8'd38,8'd38,8'd39,8'd39,8'd40,8'd41,8'd41,
      8'd42,8'd42,8'd43,8'd44,8'd44,8'd45,8'd45,8'd46,8'd46,8'd47,8'd48,8'd48,8'd49,
      8'd49,8'd50,8'd51,8'd51,8'd52,8'd52,8'd53,8'd53,8'd54,8'd55,8'd55,8'd56,8'd56,
      8'd57,8'd57,8'd58,8'd58,8'd59,8'd60,8'd60,8'd61,8'd61,8'd62,8'd62,8'd63,8'd63,
      8'd64,8'd65,8'd65,8'd66,8'd66,8'd67,8'd67,8'd68,8'd68,8'd69,8'd69,8'd70,8'd70,
      8'd71,8'd71,8'd72,8'd72,8'd73,8'd74,8'd74,8'd75,8'd75,8'd76,8'd76,8'd77,8'd77,
      8'd78,8'd78,8'd79,8'd79,8'd80,8'd80,8'd81,8'd81,8'd82,8'd82,8'd83,8'd83,8'd84,
      8'd84,8'd84,8'd85,8'd85,8'd86,8'd86,8'd87,8'd87,8'd88,8'd88,8'd89,8'd89,8'd90,
      8'd90,8'd91,8'd91,8'd91,8'd92,8'd92,8'd93,8'd93,8'd94,8'd94,8'd95,8'd95,8'd96,
      8'd96,8'd96,8'd97,8'd97,8'd98,8'd98,8'd99,8'd99,8'd99,8'd100,8'd100,8'd101,
      8'd101,8'd102,8'd102,8'd102,8'd103,8'd103,8'd104,8'd104,8'd104,8'd105,8'd105,
      8'd106,8'd106,8'd106,8'd107,8'd107,8'd108,8'd108,8'd108,8'd109,8'd109,8'd110,
      8'd110,8'd110,8'd111,8'd111,8'd112,8'd112,8'd112,8'd113,8'd113,8'd113,8'd114,
      8'd114,8'd115,8'd115,8'd115,8'd116,8'd116,8'd116,8'd117,8'd117,8'd118,8'd118,
      8'd118,8'd119,8'd119,8'd119,8'd120,8'd120,8'd120,8'd121,8'd121,8'd121,8'd122,
      8'd122,8'd122,8'd123,8'd123,8'd123,8'd124,8'd124,8'd124,8'd125,8'd125,8'd125,
      8'd126,8'd126,8'd126,8'd127,8'd127,8'd127,8'd128,8'd128,8'd0
    };
    atan_lookup = (idx > 9'd257) ? tab[257] : tab[idx];
  endfunction

endpackage

@@ hw/rtl/lao_if.sv @@
interface lao_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [lao_pkg::CoordW-1:0]  x_coord;
  logic signed [lao_pkg::CoordW-1:0]  y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface lao_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lao_pkg::AngleW-1:0]  angle;
  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

@@ hw/rtl/lut_atan2_octant.sv @@
// Octant-folding arctangent of a signed coordinate pair.
// Input channel in_: beats carry x_coord and y_coord (16-bit signed).
// Output channel out_: beats carry angle, 11-bit signed, 1024 units per
// turn, angle 0 along +y. An input of -32768 counts as -32767.
// Throughput: one beat per cycle while the receiver keeps out_ready high.
// Pipeline: 20 register stages. Stage 1 folds and orders the magnitudes,
// stages 2..17 run a restoring divider, one quotient bit per stage (16
// stages), stage 18 rounds, stage 19 reads the arctangent table, stage
// 20 unfolds by octant into the output register.
// The divider's one-bit-per-stage chain sets the latency.
// Reset clears every stage's valid bit; payload registers are not reset.
// When the receiver drops out_ready the full stages hold: in_ready is high
// while out_ready is high or any stage is empty, so no beat is lost or
// repeated, and beats behind bubbles still advance.
`include "assert_macros.svh"

module lut_atan2_octant (
  input  logic   clk,
  input  logic   rst_n,
  lao_in_if.sink in_,
  lao_out_if.source out_
);

  localparam int unsigned NDiv = lao_pkg::CoordW;
  localparam int unsigned NSt  = NDiv + 4;
  localparam int unsigned MW   = lao_pkg::MagW;

  logic [NSt-1:0] vld_r;
  logic [NSt-1:0] adv;

  lao_pkg::ctl_t            ctl_r   [NSt];
  logic [MW-1:0]            hi_r    [NDiv+1];
  logic [MW:0]              rem_r   [NDiv+1];
  logic [lao_pkg::QuotW-1:0] quo_r  [NDiv+1];
  logic [lao_pkg::TabAW-1:0] idx_r;
  lao_pkg::tab_t            t_r;
  logic [lao_pkg::AngleW-1:0] ang_r;

  always_comb begin
    adv[NSt-1] = !vld_r[NSt-1] || out_.ready;
    for (int i = NSt - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_.ready  = adv[0];
  assign out_.valid = vld_r[NSt-1];
  assign out_.angle = ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_.valid;
      for (int i = 1; i < NSt; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  logic [MW-1:0] a_mag, b_mag;
  logic          xn, yn;
  lao_pkg::ctl_t c0;

  function automatic logic [MW-1:0] fold(input logic [lao_pkg::CoordW-1:0] v);
    logic [lao_pkg::CoordW-1:0] n;
    n = -v;
    if (!v[lao_pkg::CoordW-1]) fold = v[MW-1:0];
    else if (n[lao_pkg::CoordW-1]) fold = {MW{1'b1}};
    else fold = n[MW-1:0];
  endfunction

  always_comb begin
    xn    = in_.x_coord[lao_pkg::CoordW-1];
    yn    = in_.y_coord[lao_pkg::CoordW-1];
    a_mag = fold(in_.x_coord);
    b_mag = fold(in_.y_coord);
    c0.oct  = {xn, yn, a_mag > b_mag};
    c0.zero = (a_mag == b_mag) && (a_mag == '0);
    c0.diag = (a_mag == b_mag);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ctl_r[0] <= c0;
      hi_r[0]  <= (a_mag > b_mag) ? a_mag : b_mag;
      rem_r[0] <= {1'b0, (a_mag > b_mag) ? b_mag : a_mag};
      quo_r[0] <= '0;
    end
  end

  // one quotient bit per stage: quotient = (lo << 16) / hi, lo < hi
  for (genvar g = 0; g < NDiv; g++) begin : g_div
    logic [MW+1:0] sh;
    logic [MW+1:0] dif;
    always_comb begin
      sh  = {rem_r[g], 1'b0};
      dif = sh - {2'b00, hi_r[g]};
    end
    always_ff @(posedge clk) begin
      if (adv[g+1]) begin
        ctl_r[g+1] <= ctl_r[g];
        hi_r[g+1]  <= hi_r[g];
        if (!dif[MW+1]) begin
          rem_r[g+1] <= dif[MW:0];
          quo_r[g+1] <= {quo_r[g][lao_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= sh[MW:0];
          quo_r[g+1] <= {quo_r[g][lao_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
  end

  logic [lao_pkg::QuotW:0] qr;
  assign qr = {1'b0, quo_r[NDiv]} + (lao_pkg::QuotW+1)'(8'h80);

  always_ff @(posedge clk) begin
    if (adv[NDiv+1]) begin
      ctl_r[NDiv+1] <= ctl_r[NDiv];
      idx_r         <= qr[lao_pkg::QuotW-1:8];
    end
    if (adv[NDiv+2]) begin
      ctl_r[NDiv+2] <= ctl_r[NDiv+1];
      t_r           <= ctl_r[NDiv+1].diag ? lao_pkg::DiagAngle
                                          : lao_pkg::atan_lookup(idx_r);
    end
  end

  logic [lao_pkg::AngleW-1:0] t_ext, ang_nxt;
  lao_pkg::ctl_t cl;
  assign cl    = ctl_r[NDiv+2];
  assign t_ext = {3'b000, t_r};

  always_comb begin
    case (cl.diag ? {cl.oct[2:1], 1'b0} : cl.oct)
      lao_pkg::OCT_PP:  ang_nxt = t_ext;
      lao_pkg::OCT_PPS: ang_nxt = lao_pkg::Quarter - t_ext;
      lao_pkg::OCT_PN:  ang_nxt = lao_pkg::Half - t_ext;
      lao_pkg::OCT_PNS: ang_nxt = t_ext + lao_pkg::Quarter;
      lao_pkg::OCT_NP:  ang_nxt = -t_ext;
      lao_pkg::OCT_NPS: ang_nxt = t_ext - lao_pkg::Quarter;
      lao_pkg::OCT_NN:  ang_nxt = t_ext - lao_pkg::Half;
      default:          ang_nxt = -(t_ext + lao_pkg::Quarter);
    endcase
    if (cl.zero) ang_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (adv[NSt-1]) begin
      ctl_r[NSt-1] <= cl;
      ang_r        <= ang_nxt;
    end
  end

  `ASSERT_CLK(a_hold_on_stall,
              out_.valid && !out_.ready |=> out_.valid && $stable(out_.angle),
              "output beat changed while stalled")
  `ASSERT_CLK(a_ready_path, !out_.ready && (&vld_r) |-> !in_.ready,
              "input taken with full stalled pipe")
  `ASSERT_CLK(a_range,
              out_.valid |-> ($signed(out_.angle) <= 512 && $signed(out_.angle) >= -512),
              "angle out of range")
  `ASSERT_RST(a_reset_empty, !rst_n |=> !out_.valid, "output valid after reset")

endmodule
